[sv/iirdf_pkg.sv]
`default_nettype none

package iirdf_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 18;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + 4;
  localparam int ROUND_SHIFT = 14;
  localparam int YWIDE_W     = ACC_W - ROUND_SHIFT;
  localparam int NUM_TAPS    = 3;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [YWIDE_W-1:0]  ywide_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_index_t;

  // Register indexes on the configuration port.
  localparam cfg_index_t REG_B0 = 3'd0;
  localparam cfg_index_t REG_B1 = 3'd1;
  localparam cfg_index_t REG_B2 = 3'd2;
  localparam cfg_index_t REG_B3 = 3'd3;
  localparam cfg_index_t REG_A1 = 3'd4;
  localparam cfg_index_t REG_A2 = 3'd5;
  localparam cfg_index_t REG_A3 = 3'd6;

  // Coefficient reset values (Q4.14).
  localparam coef_t COEF_ONE  = 18'sd16384;
  localparam coef_t COEF_ZERO = 18'sd0;

  // Half an output LSB at the accumulator scale, for round to nearest.
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (ROUND_SHIFT - 1);

  typedef struct packed {
    sample_t sample_in;
    logic    start_block;
  } in_word_t;

  typedef struct packed {
    sample_t sample_out;
    logic    saturated;
  } out_word_t;

  // Control handed from the top level to every tap cell.
  typedef struct packed {
    logic fire;   // the output stage produces a result this cycle
    logic clear;  // the word in the product stage starts a new block
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/iirdf_tap_cell.sv]
`default_nettype none

module iirdf_tap_cell #(
  parameter bit USE_B = 1'b1,
  parameter bit USE_A = 1'b1
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire iirdf_pkg::cell_ctrl_t ctrl,
  input  wire iirdf_pkg::sample_t    x_in,
  input  wire iirdf_pkg::sample_t    y_in,
  input  wire iirdf_pkg::coef_t      coef_b,
  input  wire iirdf_pkg::coef_t      coef_a,
  input  wire iirdf_pkg::acc_t       partial_in,
  output iirdf_pkg::sample_t         x_out,
  output iirdf_pkg::sample_t         y_out,
  output iirdf_pkg::acc_t            partial_out
);
  import iirdf_pkg::*;

  sample_t x_hist;
  sample_t y_hist;
  prod_t   ff_prod;
  prod_t   fb_prod;
  acc_t    term;

  // Delay line: on each result, take the neighbor's samples and pass ours on.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_hist <= '0;
      y_hist <= '0;
    end else if (ctrl.fire) begin
      x_hist <= x_in;
      y_hist <= y_in;
    end
  end

  // A new block sees zero history from this tap onward.
  assign x_out = ctrl.clear ? '0 : x_hist;
  assign y_out = ctrl.clear ? '0 : y_hist;

  // Products of this tap on the held input and output samples.
  assign ff_prod = USE_B ? prod_t'(coef_b * x_hist) : '0;
  assign fb_prod = USE_A ? prod_t'(coef_a * y_hist) : '0;

  // Partial sum of this tap and all taps further down the chain.
  assign term        = ctrl.clear ? '0 : acc_t'(ff_prod) - acc_t'(fb_prod);
  assign partial_out = term + partial_in;

endmodule

`default_nettype wire

[sv/iir_direct_form_filter.sv]
`default_nettype none

// Direct-form I IIR filter of up to third order both ways, built as a chain
// of tap cells. Each cell holds one delayed input and one delayed output, adds
// its two products to the partial sum of the cells behind it, and hands its
// samples on to the next cell with every result. The block takes one Q1.15
// sample word per clock and gives one rounded, saturated Q1.15 word per clock
// while the output is taken. The current-input product is registered on
// acceptance; when the output stage fires, the cell terms are summed,
// rounded and saturated into the output register, and the same value
// enters the output history, so the path from the history through a
// feedback multiplier and the sum sets the clock rate. The input is held
// off only while a word waits in the product stage behind an output word
// not yet taken. A word with start_block set discards all history before
// it. Coefficients are written over the configuration port, one per cycle;
// the user must write only while the filter is idle, unchecked by the block.
module iir_direct_form_filter #(
  parameter int FEEDFORWARD_ORDER = 3,
  parameter int FEEDBACK_ORDER    = 3
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire iirdf_pkg::in_word_t   in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output iirdf_pkg::out_word_t       out_data,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire iirdf_pkg::cfg_index_t cfg_index,
  input  wire iirdf_pkg::coef_t      cfg_data
);
  import iirdf_pkg::*;

  coef_t      coef_b0;
  coef_t      coef_b [1:NUM_TAPS];
  coef_t      coef_a [1:NUM_TAPS];
  logic       prod_valid;
  logic       start_ff;
  sample_t    x_ff;
  prod_t      b0_prod;
  logic       load;
  cell_ctrl_t ctrl;
  acc_t       partial [1:NUM_TAPS+1];
  sample_t    x_link [1:NUM_TAPS+1];
  sample_t    y_link [1:NUM_TAPS+1];
  acc_t       acc;
  acc_t       acc_rounded;
  ywide_t     y_wide;
  logic       sat_hi;
  logic       sat_lo;
  sample_t    y_sat;

  // Configuration writes are always taken; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_ONE;
      for (int k = 1; k <= NUM_TAPS; k++) begin
        coef_b[k] <= COEF_ZERO;
        coef_a[k] <= COEF_ZERO;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B0:  coef_b0   <= cfg_data;
        REG_B1:  coef_b[1] <= cfg_data;
        REG_B2:  coef_b[2] <= cfg_data;
        REG_B3:  coef_b[3] <= cfg_data;
        REG_A1:  coef_a[1] <= cfg_data;
        REG_A2:  coef_a[2] <= cfg_data;
        REG_A3:  coef_a[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: a product-stage word fires when the output register is free.
  always_comb begin
    ctrl.fire  = prod_valid && (!out_valid || out_ready);
    ctrl.clear = start_ff;
    load       = in_valid && in_ready;
    in_ready   = !prod_valid || ctrl.fire;
  end

  // Product stage: the current-input tap lives here, the history in the cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_ff <= in_data.start_block;
      x_ff     <= in_data.sample_in;
      b0_prod  <= prod_t'(coef_b0 * in_data.sample_in);
    end
  end

  // Chain of tap cells; the first takes the newest samples, the last sees an
  // empty neighbor.
  assign partial[NUM_TAPS+1] = '0;
  assign x_link[1]           = x_ff;
  assign y_link[1]           = y_sat;

  for (genvar k = 1; k <= NUM_TAPS; k++) begin : g_tap
    iirdf_tap_cell #(
      .USE_B (FEEDFORWARD_ORDER >= k),
      .USE_A (FEEDBACK_ORDER >= k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .x_in        (x_link[k]),
      .y_in        (y_link[k]),
      .coef_b      (coef_b[k]),
      .coef_a      (coef_a[k]),
      .partial_in  (partial[k+1]),
      .x_out       (x_link[k+1]),
      .y_out       (y_link[k+1]),
      .partial_out (partial[k])
    );
  end

  // Sum, round to nearest with ties up, then saturate to 16 bits.
  always_comb begin
    acc         = acc_t'(b0_prod) + partial[1];
    acc_rounded = acc + ROUND_HALF;
    y_wide      = acc_rounded[ACC_W-1:ROUND_SHIFT];
    sat_hi      = !y_wide[YWIDE_W-1] && (|y_wide[YWIDE_W-2:SAMPLE_W-1]);
    sat_lo      = y_wide[YWIDE_W-1] && !(&y_wide[YWIDE_W-2:SAMPLE_W-1]);
    if (sat_hi) begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = y_wide[SAMPLE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      out_data.sample_out <= y_sat;
      out_data.saturated  <= sat_hi || sat_lo;
    end
  end

endmodule

`default_nettype wire
